### rtl/assert_macros.svh
// Assertion macros used by the port-level checker.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, masked while reset is high.
`define RHT_ASSERT(lbl, clk_s, rst_s, prop, msg) \
  lbl: assert property (@(posedge clk_s) disable iff (rst_s) (prop)) else $error(msg);

// Overlapping implication built on the macro above.
`define RHT_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
  `RHT_ASSERT(lbl, clk_s, rst_s, (ante) |-> (cons), msg)

`endif

### rtl/rht_pkg.sv
// Shared types and constants for the refcounted handle table.
// No dependencies.
package rht_pkg;

  localparam int SLOTS      = 64;
  localparam int COUNT_BITS = 16;
  localparam int HANDLE_W   = 6;
  localparam int PAGES_W    = 16;
  localparam int OWNERS_W   = 16;
  localparam int MAX_HANDLES = 1 << HANDLE_W;
  localparam int USABLE     = (SLOTS < MAX_HANDLES) ? SLOTS : MAX_HANDLES;
  localparam int SLOT_W     = (USABLE > 1) ? $clog2(USABLE) : 1;

  typedef logic [COUNT_BITS-1:0] count_t;
  typedef logic [SLOT_W-1:0]     slot_t;

  localparam count_t COUNT_MAX = '1;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_RETAIN  = 2'd1,
    OP_RELEASE = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_OK         = 3'd0,
    ST_ZERO_PAGES = 3'd1,
    ST_FULL       = 3'd2,
    ST_RANGE      = 3'd3,
    ST_DEAD       = 3'd4,
    ST_SAT        = 3'd5
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FIND,
    S_READ,
    S_EXEC
  } state_t;

  // Controller to datapath commands, one step per bit.
  typedef struct packed {
    logic latch;
    logic find;
    logic read;
    logic exec;
  } cmd_t;

  function automatic logic [OWNERS_W-1:0] to_owners(input count_t c);
    return OWNERS_W'(c);
  endfunction

endpackage

### rtl/rht_ctrl.sv
// Sequencing state machine for the refcounted handle table.
// Depends on rht_pkg.
module rht_ctrl import rht_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic start,
  output logic busy,
  output logic done,
  output cmd_t cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      done  <= cmd.exec;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    case (state)
      S_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.latch  = 1'b1;
          state_next = S_FIND;
        end
      end
      S_FIND: begin
        cmd.find   = 1'b1;
        state_next = S_READ;
      end
      S_READ: begin
        cmd.read   = 1'b1;
        state_next = S_EXEC;
      end
      S_EXEC: begin
        cmd.exec   = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

### rtl/rht_dpath.sv
// Datapath: owner-count memory, live map, free-slot encoder and result registers.
// Depends on rht_pkg; driven by rht_ctrl commands.
module rht_dpath import rht_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  cmd_t                cmd,
  input  logic [1:0]          operation,
  input  logic [HANDLE_W-1:0] handle,
  input  logic [PAGES_W-1:0]  page_count,
  output logic [2:0]          status,
  output logic [HANDLE_W-1:0] handle_out,
  output logic                freed,
  output logic [OWNERS_W-1:0] owners
);

  count_t              mem [USABLE];
  logic [USABLE-1:0]   live;

  op_t                 op_q;
  logic [HANDLE_W-1:0] handle_q;
  logic                zero_pages_q;
  logic                in_range_q;
  slot_t               slot;
  logic                found;
  count_t              rd_data;

  slot_t               free_idx;
  logic                free_any;

  count_t              cur;
  count_t              wr_data;
  logic                we;
  status_t             st_next;
  logic [HANDLE_W-1:0] h_next;
  logic                freed_next;
  logic [OWNERS_W-1:0] owners_next;

  // Lowest clear bit of the live map.
  always_comb begin
    free_idx = '0;
    free_any = 1'b0;
    for (int i = USABLE - 1; i >= 0; i--) begin
      if (!live[i]) begin
        free_idx = SLOT_W'(i);
        free_any = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      op_q         <= op_t'(operation);
      handle_q     <= handle;
      zero_pages_q <= (page_count == '0);
      in_range_q   <= ((HANDLE_W + 1)'(handle) < (HANDLE_W + 1)'(USABLE));
    end
    if (cmd.find) begin
      slot  <= (op_q == OP_CREATE) ? free_idx : handle_q[SLOT_W-1:0];
      found <= free_any;
    end
    if (cmd.read) begin
      rd_data <= mem[slot];
    end
  end

  always_comb begin
    cur         = (in_range_q && live[slot]) ? rd_data : '0;
    wr_data     = cur;
    we          = 1'b0;
    st_next     = ST_OK;
    h_next      = handle_q;
    freed_next  = 1'b0;
    owners_next = '0;
    case (op_q)
      OP_CREATE: begin
        h_next = '0;
        if (zero_pages_q) begin
          st_next = ST_ZERO_PAGES;
        end else if (!found) begin
          st_next = ST_FULL;
        end else begin
          we          = 1'b1;
          wr_data     = count_t'(1);
          h_next      = HANDLE_W'(slot);
          owners_next = to_owners(count_t'(1));
        end
      end
      OP_QUERY: begin
        owners_next = to_owners(cur);
      end
      OP_RETAIN, OP_RELEASE: begin
        if (!in_range_q) begin
          st_next = ST_RANGE;
        end else if (cur == '0) begin
          st_next = ST_DEAD;
        end else if (op_q == OP_RETAIN) begin
          if (cur == COUNT_MAX) begin
            st_next     = ST_SAT;
            owners_next = to_owners(cur);
          end else begin
            we          = 1'b1;
            wr_data     = cur + count_t'(1);
            owners_next = to_owners(wr_data);
          end
        end else begin
          we          = 1'b1;
          wr_data     = cur - count_t'(1);
          freed_next  = (wr_data == '0);
          owners_next = to_owners(wr_data);
        end
      end
      default: st_next = ST_OK;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.exec && we) begin
      mem[slot] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else if (cmd.exec && we) begin
      live[slot] <= (wr_data != '0);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      status     <= st_next;
      handle_out <= h_next;
      freed      <= freed_next;
      owners     <= owners_next;
    end
  end

endmodule

### rtl/refcounted_handle_table.sv
// Refcounted handle table: create, retain and release of shared-buffer slots, each
// holding an owner count. An operation is taken when start is high and busy is low;
// its result appears with done, registered from the update step, and is shown for one
// cycle only; the receiver cannot stall it. Busy stays high through the steps of
// the sequencer (free-slot pick, owner-count memory read, update and write back),
// so no operation is taken while one is in flight, and the next start is taken in the
// same cycle that done is shown. All counts read as zero right after reset.
module refcounted_handle_table import rht_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  output logic                done,
  input  logic [1:0]          operation,
  input  logic [HANDLE_W-1:0] handle,
  input  logic [PAGES_W-1:0]  page_count,
  output logic [2:0]          status,
  output logic [HANDLE_W-1:0] handle_out,
  output logic                freed,
  output logic [OWNERS_W-1:0] owners
);

  cmd_t cmd;

  rht_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .done  (done),
    .cmd   (cmd)
  );

  rht_dpath u_dpath (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .operation  (operation),
    .handle     (handle),
    .page_count (page_count),
    .status     (status),
    .handle_out (handle_out),
    .freed      (freed),
    .owners     (owners)
  );

endmodule

### rtl/rht_checker.sv
// Port-level checks for the refcounted handle table, bound to the top level.
// Depends on rht_pkg and assert_macros.svh.
`include "assert_macros.svh"

module rht_checker import rht_pkg::*; (
  input logic                clk,
  input logic                rst,
  input logic                start,
  input logic                busy,
  input logic                done,
  input logic [2:0]          status,
  input logic [HANDLE_W-1:0] handle_out,
  input logic                freed,
  input logic [OWNERS_W-1:0] owners
);

  logic zp_done;
  logic res_clean;
  logic freed_ok;

  assign zp_done   = done && (status == ST_ZERO_PAGES);
  assign res_clean = (owners == '0) && (handle_out == '0) && !freed;
  assign freed_ok  = (owners == '0) && (status == ST_OK);

  `RHT_ASSERT_IMP(a_done_idle, clk, rst, done, !busy, "result shown while busy")
  `RHT_ASSERT(a_latency, clk, rst, (start && !busy) |-> ##4 done, "result latency wrong")
  `RHT_ASSERT(a_busy_after, clk, rst, (start && !busy) |=> busy, "busy not raised")
  `RHT_ASSERT_IMP(a_zero_pages, clk, rst, zp_done, res_clean, "zero-page result not clean")
  `RHT_ASSERT_IMP(a_freed, clk, rst, done && freed, freed_ok, "freed with live owners")

endmodule

bind refcounted_handle_table rht_checker u_rht_checker (
  .clk        (clk),
  .rst        (rst),
  .start      (start),
  .busy       (busy),
  .done       (done),
  .status     (status),
  .handle_out (handle_out),
  .freed      (freed),
  .owners     (owners)
);
